FILE: sv/clamped_linear_range_mapper_unit_defines.svh
// assertion helpers shared by the mapper rtl
`ifndef CLAMPED_LINEAR_RANGE_MAPPER_UNIT_DEFINES_SVH
`define CLAMPED_LINEAR_RANGE_MAPPER_UNIT_DEFINES_SVH

// same-cycle implication, masked while in reset
`define CLRM_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mapper check failed");

// next-cycle implication, masked while in reset
`define CLRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mapper check failed");

`endif

FILE: sv/clrm_pkg.sv
package clrm_pkg;

	localparam int unsigned DATA_W = 32;
	// quotient bits produced by the divider, one per cycle
	localparam int unsigned DIV_STEPS = 34;
	localparam int unsigned CNT_W = $clog2(DIV_STEPS);
	// largest input span that needs no halving
	localparam logic [32:0] MAP_LIMIT = 33'd2147483647;

	typedef enum logic [1:0] {
		REG_IN_LOW   = 2'd0,
		REG_IN_HIGH  = 2'd1,
		REG_OUT_LOW  = 2'd2,
		REG_OUT_HIGH = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MULT,
		ST_PRODUCT,
		ST_DIV,
		ST_FIX,
		ST_EMIT
	} state_t;

	// signed halving, truncated toward zero
	function automatic logic [DATA_W-1:0] half_tz(input logic [DATA_W-1:0] x);
		logic [DATA_W-1:0] t;
		t = x + {{(DATA_W-1){1'b0}}, x[DATA_W-1]};
		return {t[DATA_W-1], t[DATA_W-1:1]};
	endfunction

endpackage

FILE: sv/clamped_linear_range_mapper_unit.sv
// channel   signals                              direction  word
// -------   -----------------------------------  ---------  -------------------------
// in        in_valid, in_ready, sample           into       one sample to map
// out       out_valid, out_ready, mapped         out of     one mapped value
// cfg       cfg_valid, cfg_ready, cfg_index,     into       one bound register write,
//           cfg_data                                        cfg_ready held high
//
// sequence: per pass a check and a multiply step, repeated halving passes as needed,
//   then product, divider, fix-up and emit steps; clamped or empty-range
//   samples take a check and an emit step; one sample at a time (radix-2 divider)
// reset: arst_n clears the sequencer, the output word and the bound registers to 0
// stalls: the finished word waits in an output register while the next sample is
//   taken; the sequencer holds in emit only if that register is still full

`include "clamped_linear_range_mapper_unit_defines.svh"

module clamped_linear_range_mapper_unit (
	input  logic        clk,
	input  logic        arst_n,
	// sample channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] sample,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] mapped,
	// bound register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// bound registers
	logic [31:0] in_low_q, in_high_q, out_low_q, out_high_q;

	// sequencer
	clrm_pkg::state_t state_q, state_d;

	// working ranges: input a..b (a <= b), output c..d paired with them
	logic [31:0] v_q, a_q, b_q, c_q, d_q;
	// offset into input range, later 1-based position
	logic [32:0] x_q;
	// output span, later output count
	logic [32:0] s_q;
	logic [31:0] span_q;   // b - a
	logic        big_q;    // input span too wide, halve without multiplying
	logic        rise_q;   // output range rises
	logic [33:0] num_q;    // dividend, shifts into quotient
	logic [31:0] div_q;    // input count
	logic [31:0] rem_q;
	logic [clrm_pkg::CNT_W-1:0] cnt_q;
	logic [31:0] res_q;
	logic [31:0] mapped_q;
	logic        out_valid_q;

	// check-stage terms
	logic        at_low, at_high, flat, rise;
	logic [32:0] x_full, dc, s_full, ba;
	logic        big;

	// shared multiplier
	logic [65:0] prod;
	logic        over;

	// halving terms
	logic [31:0] mid, tmid;
	logic        go_up;

	// divider step
	logic [32:0] trial, diff;
	logic        qbit;

	// fix-up
	logic [33:0] fix_sum;

	logic in_fire, out_fire, slot_free;

	assign in_ready  = (state_q == clrm_pkg::ST_IDLE);
	assign in_fire   = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign mapped    = mapped_q;
	assign out_fire  = out_valid_q & out_ready;
	assign slot_free = ~out_valid_q | out_ready;
	assign cfg_ready = 1'b1;

	// bound register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_low_q   <= '0;
			in_high_q  <= '0;
			out_low_q  <= '0;
			out_high_q <= '0;
		end else if (cfg_valid) begin
			case (clrm_pkg::cfg_reg_t'(cfg_index))
				clrm_pkg::REG_IN_LOW:   in_low_q   <= cfg_data;
				clrm_pkg::REG_IN_HIGH:  in_high_q  <= cfg_data;
				clrm_pkg::REG_OUT_LOW:  out_low_q  <= cfg_data;
				clrm_pkg::REG_OUT_HIGH: out_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp, empty-range and overflow checks on the current ranges
	assign at_low  = $signed(v_q) <= $signed(a_q);
	assign at_high = $signed(v_q) >= $signed(b_q);
	assign flat    = (c_q == d_q);
	assign rise    = $signed(c_q) < $signed(d_q);
	assign x_full  = {v_q[31], v_q} - {a_q[31], a_q};
	assign dc      = {d_q[31], d_q} - {c_q[31], c_q};
	assign s_full  = dc[32] ? (33'd0 - dc) : dc;
	assign ba      = {b_q[31], b_q} - {a_q[31], a_q};
	assign big     = ba > clrm_pkg::MAP_LIMIT;

	// one multiplier: offset * span for the overflow test, then position * count
	assign prod = {33'd0, x_q} * {33'd0, s_q};
	assign over = big_q | (|prod[65:31]);

	// midpoints of both ranges
	assign mid   = clrm_pkg::half_tz(a_q) + clrm_pkg::half_tz(b_q);
	assign tmid  = clrm_pkg::half_tz(c_q) + clrm_pkg::half_tz(d_q);
	assign go_up = $signed(v_q) > $signed(mid);

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, num_q[33]};
	assign diff  = trial - {1'b0, div_q};
	assign qbit  = ~diff[32];

	// place the ceiling-rounded position in the output range
	assign fix_sum = rise_q ? ({{2{c_q[31]}}, c_q} + {1'b0, num_q[32:0]} - 34'd1)
	                        : ({{2{c_q[31]}}, c_q} - {1'b0, num_q[32:0]} + 34'd1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			clrm_pkg::ST_IDLE: begin
				if (in_fire) state_d = clrm_pkg::ST_PREP;
			end
			clrm_pkg::ST_PREP: begin
				if (at_low || at_high || flat) state_d = clrm_pkg::ST_EMIT;
				else state_d = clrm_pkg::ST_MULT;
			end
			clrm_pkg::ST_MULT: begin
				// halve and test again, or the product fits
				if (over) state_d = clrm_pkg::ST_PREP;
				else state_d = clrm_pkg::ST_PRODUCT;
			end
			clrm_pkg::ST_PRODUCT: begin
				state_d = clrm_pkg::ST_DIV;
			end
			clrm_pkg::ST_DIV: begin
				if (cnt_q == clrm_pkg::CNT_W'(clrm_pkg::DIV_STEPS - 1)) begin
					state_d = clrm_pkg::ST_FIX;
				end
			end
			clrm_pkg::ST_FIX: begin
				state_d = clrm_pkg::ST_EMIT;
			end
			clrm_pkg::ST_EMIT: begin
				if (slot_free) state_d = clrm_pkg::ST_IDLE;
			end
			default: state_d = clrm_pkg::ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			clrm_pkg::ST_IDLE: begin
				if (in_fire) begin
					v_q <= sample;
					// reversed input bounds swap both pairs
					if ($signed(in_low_q) > $signed(in_high_q)) begin
						a_q <= in_high_q;
						b_q <= in_low_q;
						c_q <= out_high_q;
						d_q <= out_low_q;
					end else begin
						a_q <= in_low_q;
						b_q <= in_high_q;
						c_q <= out_low_q;
						d_q <= out_high_q;
					end
				end
			end
			clrm_pkg::ST_PREP: begin
				if (at_low)       res_q <= c_q;
				else if (at_high) res_q <= d_q;
				else              res_q <= c_q;
				x_q    <= x_full;
				s_q    <= s_full;
				span_q <= ba[31:0];
				big_q  <= big;
				rise_q <= rise;
			end
			clrm_pkg::ST_MULT: begin
				if (over) begin
					if (go_up) begin
						a_q <= mid;
						c_q <= tmid;
					end else begin
						b_q <= mid;
						d_q <= tmid;
					end
				end else begin
					x_q <= x_q + 33'd1;
					s_q <= s_q + 33'd1;
				end
			end
			clrm_pkg::ST_PRODUCT: begin
				// ceiling bias: pos * count + input count - 1
				num_q <= prod[33:0] + {2'b00, span_q};
				div_q <= span_q + 32'd1;
				rem_q <= '0;
				cnt_q <= '0;
			end
			clrm_pkg::ST_DIV: begin
				rem_q <= qbit ? diff[31:0] : trial[31:0];
				num_q <= {num_q[32:0], qbit};
				cnt_q <= cnt_q + clrm_pkg::CNT_W'(1);
			end
			clrm_pkg::ST_FIX: begin
				res_q <= fix_sum[31:0];
			end
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mapped_q    <= '0;
		end else if (state_q == clrm_pkg::ST_EMIT && slot_free) begin
			out_valid_q <= 1'b1;
			mapped_q    <= res_q;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	// halving keeps the input range ordered
	`CLRM_ASSERT_HOLDS(a_range_ordered, clk, arst_n, state_q == clrm_pkg::ST_PREP,
		$signed(a_q) <= $signed(b_q))
	// divider remainder stays below the divisor
	`CLRM_ASSERT_HOLDS(a_rem_bound, clk, arst_n, state_q == clrm_pkg::ST_DIV, rem_q < div_q)
	// a taken sample starts the checks
	`CLRM_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_fire, state_q == clrm_pkg::ST_PREP)
	// a result with a free slot shows up on the output
	`CLRM_ASSERT_NEXT(a_emit_shows, clk, arst_n, state_q == clrm_pkg::ST_EMIT && slot_free,
		out_valid && mapped == $past(res_q))

endmodule

FILE: bench/tb_clamped_linear_range_mapper_unit.sv
module tb_clamped_linear_range_mapper_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// run shape
	localparam int unsigned RANDOM_PHASES   = 15;
	localparam int unsigned ITEMS_PER_PHASE = 30;
	localparam int unsigned MAX_IDLE        = 17;
	// the slowest sample plus a receiver stall fits inside this, so it covers the tail
	localparam int unsigned END_SETTLE      = 150;
	localparam int unsigned CYCLE_LIMIT     = 1_000_000;
	localparam int unsigned REPORT_LIMIT    = 10;
	// halving stops after this many passes, never reached with legal bounds
	localparam int unsigned HALVING_CAP     = 64;
	localparam longint      MAP_CEILING     = 64'sd2147483647;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] sample = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] mapped;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = clrm_pkg::REG_IN_LOW;
	logic [31:0] cfg_data = '0;

	// shadow copy of the bound registers, all zero out of reset
	logic signed [31:0] bound_q [4] = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
	// mapped words still owed by the block, oldest first
	logic [31:0]        pending_mapped [$];
	int unsigned        mismatch_count = 0;
	int unsigned        cycle_count = 0;
	// idling on or off per side, flipped now and then for stretches without gaps
	bit                 sender_idles = 1'b1;
	bit                 receiver_idles = 1'b1;
	int unsigned        stall_left = 0;

	clamped_linear_range_mapper_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.mapped    (mapped),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// --------------------------------------------------------------------------
	// expected mapping, exact in 64-bit arithmetic
	// --------------------------------------------------------------------------
	function automatic logic [31:0] mapped_value_of(input logic signed [31:0] smp);
		longint v, a, b, c, d, t, span, mid, tmid, niv, nov, pos, newpos;
		v = smp;
		a = bound_q[clrm_pkg::REG_IN_LOW];
		b = bound_q[clrm_pkg::REG_IN_HIGH];
		c = bound_q[clrm_pkg::REG_OUT_LOW];
		d = bound_q[clrm_pkg::REG_OUT_HIGH];
		for (int pass = 0; pass < HALVING_CAP; pass++) begin
			// reversed input bounds drag the output bounds along
			if (a > b) begin
				t = a; a = b; b = t;
				t = c; c = d; d = t;
			end
			// clamp at or past either input bound
			if (v <= a) return 32'(c);
			if (v >= b) return 32'(d);
			// empty output range
			if (c == d) return 32'(c);
			span = (d > c) ? d - c : c - d;
			// product and input width both fit, no more halving needed
			if (MAP_CEILING / span >= v - a && MAP_CEILING - b >= -a) break;
			// split both ranges at truncated midpoints, keep the half holding the sample
			mid  = a / 2 + b / 2;
			tmid = c / 2 + d / 2;
			if (v > mid) begin
				a = mid;
				c = tmid;
			end else begin
				b = mid;
				d = tmid;
			end
		end
		// balanced ceiling-rounded position, 1-based on both sides
		niv    = b - a + 1;
		nov    = ((d > c) ? d - c : c - d) + 1;
		pos    = v - a + 1;
		newpos = (pos * nov + niv - 1) / niv;
		return (c < d) ? 32'(c + newpos - 1) : 32'(c - newpos + 1);
	endfunction

	function automatic int unsigned draw_idle(input bit idles);
		return idles ? $urandom_range(0, MAX_IDLE) : 0;
	endfunction

	task automatic report_mismatch(input string why, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] mapped %s: expected %h got %h", $time, why, want, got);
	endtask

	// --------------------------------------------------------------------------
	// sample channel driver
	// --------------------------------------------------------------------------
	// valid is only lowered when a gap is taken, so back-to-back words keep it high
	task automatic send_sample(input logic [31:0] smp);
		int unsigned gap;
		gap = draw_idle(sender_idles);
		if ($urandom_range(0, 15) == 0) sender_idles = !sender_idles;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= smp;
		do @(posedge clk); while (!in_ready);
		// word taken at this edge, bounds are stable while samples flow
		pending_mapped.push_back(mapped_value_of(smp));
	endtask

	// hold off the sample channel until every owed word is back;
	// always waits on a clock edge so valid never toggles twice in a step
	task automatic wait_all_mapped();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_mapped.size() != 0);
	endtask

	// writes all four bounds back to back once the block has gone quiet
	task automatic load_bounds(input logic [31:0] lo_in, input logic [31:0] hi_in,
			input logic [31:0] lo_out, input logic [31:0] hi_out);
		logic [31:0]        vals [4];
		clrm_pkg::cfg_reg_t regs [4];
		vals = '{lo_in, hi_in, lo_out, hi_out};
		regs = '{clrm_pkg::REG_IN_LOW, clrm_pkg::REG_IN_HIGH, clrm_pkg::REG_OUT_LOW,
			clrm_pkg::REG_OUT_HIGH};
		wait_all_mapped();
		foreach (vals[k]) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[k];
			cfg_data  <= vals[k];
			do @(posedge clk); while (!cfg_ready);
			bound_q[regs[k]] = vals[k];
		end
		cfg_valid <= 1'b0;
	endtask

	// --------------------------------------------------------------------------
	// result channel: random backpressure and in-order compare
	// --------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		logic [31:0] want;
		if (out_valid && out_ready) begin
			if (pending_mapped.size() == 0) begin
				report_mismatch("word with nothing owed", 'x, mapped);
			end else begin
				want = pending_mapped.pop_front();
				if (mapped !== want) report_mismatch("value", want, mapped);
			end
			stall_left = draw_idle(receiver_idles);
			if ($urandom_range(0, 15) == 0) receiver_idles = !receiver_idles;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// --------------------------------------------------------------------------
	// directed tests
	// --------------------------------------------------------------------------
	// bounds straight out of reset: equal input bounds and empty output range
	task automatic test_reset_bounds();
		send_sample(32'h8000_0000);
		send_sample(32'h0000_0000);
		send_sample(32'h7fff_ffff);
	endtask

	// equal input bounds: at or below picks out_low, above picks out_high
	task automatic test_equal_input_bounds();
		load_bounds(32'd5, 32'd5, 32'd7, -32'sd9);
		send_sample(32'd5);
		send_sample(32'd6);
		send_sample(32'd4);
	endtask

	// swapped input bounds with a rising output range
	task automatic test_reversed_bounds();
		load_bounds(32'd100, -32'sd100, -32'sd50, 32'd50);
		send_sample(-32'sd100);
		send_sample(32'd0);
		send_sample(32'd37);
		send_sample(32'd100);
	endtask

	// full 32-bit ranges both ways: deepest halving, then falling output
	task automatic test_full_span();
		load_bounds(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_sample(32'h8000_0001);
		send_sample(32'h7fff_fffe);
		send_sample(32'h0000_0000);
		send_sample(32'hffff_ffff);
		send_sample(32'h0000_0001);
		send_sample(32'h5555_5555);
		send_sample(32'haaaa_aaaa);
		load_bounds(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_sample(32'h0000_0000);
		send_sample(32'h7fff_fffe);
		send_sample(32'h8000_0001);
	endtask

	// empty output range inside the input range, and plain ceiling rounding
	task automatic test_small_ranges();
		load_bounds(-32'sd10, 32'd10, 32'd42, 32'd42);
		send_sample(32'd0);
		load_bounds(32'd0, 32'd2, 32'd0, 32'd9);
		send_sample(32'd1);
	endtask

	// --------------------------------------------------------------------------
	// random mapping
	// --------------------------------------------------------------------------
	function automatic logic [31:0] random_bound();
		logic [31:0] edge_val;
		edge_val = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'($urandom_range(0, 400)) - 32'd200;
			2: return edge_val;
			3: return edge_val ^ 32'($urandom_range(0, 255));
			default: return {32{1'($urandom_range(0, 1))}} ^ ($urandom >> $urandom_range(0, 31));
		endcase
	endfunction

	function automatic logic [31:0] random_sample();
		longint            lo, hi;
		longint unsigned   draw;
		logic signed [31:0] near;
		lo   = (bound_q[clrm_pkg::REG_IN_LOW] < bound_q[clrm_pkg::REG_IN_HIGH])
			? bound_q[clrm_pkg::REG_IN_LOW] : bound_q[clrm_pkg::REG_IN_HIGH];
		hi   = (bound_q[clrm_pkg::REG_IN_LOW] < bound_q[clrm_pkg::REG_IN_HIGH])
			? bound_q[clrm_pkg::REG_IN_HIGH] : bound_q[clrm_pkg::REG_IN_LOW];
		draw = {$urandom};
		near = $urandom_range(0, 1) ? bound_q[clrm_pkg::REG_IN_LOW]
			: bound_q[clrm_pkg::REG_IN_HIGH];
		case ($urandom_range(0, 9))
			// mostly inside the input range where the real mapping happens
			0, 1, 2, 3, 4, 5: return 32'(lo + longint'(draw % longint'(hi - lo + 1)));
			// right around a bound
			6: return near + 32'($urandom_range(0, 4)) - 32'd2;
			7: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random_mapping();
		logic [31:0] lo_in, hi_in, lo_out, hi_out;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			lo_in  = random_bound();
			hi_in  = ($urandom_range(0, 7) == 0) ? lo_in : random_bound();
			lo_out = random_bound();
			hi_out = ($urandom_range(0, 7) == 0) ? lo_out : random_bound();
			load_bounds(lo_in, hi_in, lo_out, hi_out);
			repeat (ITEMS_PER_PHASE) begin
				// now and then let the pipe run dry mid-phase
				if ($urandom_range(0, 39) == 0) wait_all_mapped();
				send_sample(random_sample());
			end
		end
	endtask

	// --------------------------------------------------------------------------
	// sequence and end of run
	// --------------------------------------------------------------------------
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_bounds();
		test_equal_input_bounds();
		test_reversed_bounds();
		test_full_span();
		test_small_ranges();
		test_random_mapping();
		wait_all_mapped();
		// catch any stray word after the last one owed
		repeat (END_SETTLE) @(posedge clk);
		if (mismatch_count == 0 && pending_mapped.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

endmodule
